// ===== rtl/telnet_option_receive_parser_defines.svh =====
// ---------------------------------------------------------------------------
// telnet option receive parser assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef TELNET_OPTION_RECEIVE_PARSER_DEFINES_SVH
`define TELNET_OPTION_RECEIVE_PARSER_DEFINES_SVH

// same-cycle implication
`define TOR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("telnet parser check failed");

// next-cycle implication
`define TOR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("telnet parser check failed");

`endif

// ===== rtl/tor_pkg.sv =====
// ---------------------------------------------------------------------------
// tor_pkg
// shared constants, queue entry type and reply tables of the telnet parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tor_pkg;

  localparam int MAX_NAME_CHARS_DEF = 40;
  localparam int QUEUE_DEPTH        = 2;

  // telnet bytes
  localparam logic [7:0] B_IAC      = 8'd255;
  localparam logic [7:0] B_DONT     = 8'd254;
  localparam logic [7:0] B_DO       = 8'd253;
  localparam logic [7:0] B_WONT     = 8'd252;
  localparam logic [7:0] B_WILL     = 8'd251;
  localparam logic [7:0] B_SB       = 8'd250;
  localparam logic [7:0] B_SE       = 8'd240;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] OPT_TSPEED = 8'd32;
  localparam logic [7:0] SUB_IS     = 8'd0;
  localparam logic [7:0] SUB_SEND   = 8'd1;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_LOW   = 8'h1F;
  localparam logic [7:0] CHAR_HIGH  = 8'h7F;

  // result kinds
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_TX       = 3'd1;
  localparam logic [2:0] KIND_WINDOW   = 3'd2;
  localparam logic [2:0] KIND_NAME     = 3'd3;
  localparam logic [2:0] KIND_ACCEPTED = 3'd4;
  localparam logic [2:0] KIND_DISCARD  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_REPLIES_OFF = 2'd0;
  localparam logic [1:0] REG_MIN_DIM     = 2'd1;
  localparam logic [1:0] REG_MAX_DIM     = 2'd2;

  localparam logic [15:0] MIN_DIM_RESET = 16'd10;
  localparam logic [15:0] MAX_DIM_RESET = 16'd250;

  // queue entry operations
  localparam logic [2:0] OP_SIMPLE       = 3'd0;
  localparam logic [2:0] OP_WINDOW       = 3'd1;
  localparam logic [2:0] OP_REPLY_BOTH   = 3'd2;
  localparam logic [2:0] OP_REPLY_NAWS   = 3'd3;
  localparam logic [2:0] OP_REPLY_TTYPE  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic        two;
    logic [2:0]  kind0;
    logic [7:0]  val0;
    logic [2:0]  kind1;
    logic [7:0]  val1;
    logic [15:0] width;
    logic [15:0] height;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  function automatic logic [2:0] entry_len(input logic [2:0] op, input logic two);
    logic [2:0] len;
    unique case (op)
      OP_SIMPLE:      len = two ? 3'd2 : 3'd1;
      OP_WINDOW:      len = 3'd1;
      OP_REPLY_BOTH:  len = 3'd6;
      OP_REPLY_NAWS:  len = 3'd3;
      OP_REPLY_TTYPE: len = 3'd6;
      default:        len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [2:0] op, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'd0;
    unique case (op)
      OP_REPLY_BOTH: begin
        unique case (idx)
          3'd0, 3'd3: b = B_IAC;
          3'd1, 3'd4: b = B_DO;
          3'd2:       b = OPT_NAWS;
          3'd5:       b = OPT_TTYPE;
          default:    b = 8'd0;
        endcase
      end
      OP_REPLY_NAWS: begin
        unique case (idx)
          3'd0:    b = B_IAC;
          3'd1:    b = B_DO;
          3'd2:    b = OPT_NAWS;
          default: b = 8'd0;
        endcase
      end
      OP_REPLY_TTYPE: begin
        unique case (idx)
          3'd0, 3'd4: b = B_IAC;
          3'd1:       b = B_SB;
          3'd2:       b = OPT_TTYPE;
          3'd3:       b = SUB_SEND;
          3'd5:       b = B_SE;
          default:    b = 8'd0;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/tor_front.sv =====
// ---------------------------------------------------------------------------
// tor_front
// byte parser: walks the telnet command state and queues one entry per
// received byte that has results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tor_front #(
  parameter int MAX_NAME_CHARS = tor_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  logic           replies_off,
  input  logic [15:0]    min_dimension,
  input  logic [15:0]    max_dimension,
  output logic           push,
  output tor_pkg::entry_t entry
);
  import tor_pkg::*;

  localparam int NW = $clog2(MAX_NAME_CHARS + 1);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_IAC    = 4'd1;
  localparam logic [3:0] PH_OPT    = 4'd2;
  localparam logic [3:0] PH_SKIP1  = 4'd3;
  localparam logic [3:0] PH_SBOPT  = 4'd4;
  localparam logic [3:0] PH_TTIS   = 4'd5;
  localparam logic [3:0] PH_NAME   = 4'd6;
  localparam logic [3:0] PH_NAWS   = 4'd7;
  localparam logic [3:0] PH_SBSKIP = 4'd8;

  logic [3:0]    phase, phase_next;
  logic [7:0]    held_command, held_command_next;
  logic [7:0]    size_bytes [4];
  logic [7:0]    size_bytes_next [4];
  logic [2:0]    size_count, size_count_next;
  logic [NW-1:0] name_count, name_count_next;
  logic          pending_escape, pending_escape_next;

  logic          emit;
  entry_t        e;
  logic          esc_char;
  logic          byte_char;
  logic [NW-1:0] count_mid;
  logic [15:0]   raw_w, raw_h;
  logic [7:0]    mapped;

  function automatic logic [15:0] clamp_dim(input logic [15:0] x, input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  assign raw_w  = {size_bytes[0], size_bytes[1]};
  assign raw_h  = {size_bytes[2], size_bytes[3]};
  assign mapped = (rx_byte < CHAR_LOW || rx_byte > CHAR_HIGH) ? CHAR_QMARK : rx_byte;

  always_comb begin
    phase_next          = phase;
    held_command_next   = held_command;
    size_bytes_next     = size_bytes;
    size_count_next     = size_count;
    name_count_next     = name_count;
    pending_escape_next = pending_escape;
    emit                = 1'b0;
    e                   = '0;
    esc_char            = 1'b0;
    byte_char           = 1'b0;
    count_mid           = name_count;

    unique case (phase)
      PH_IAC: begin
        if (rx_byte == B_IAC) begin
          emit       = 1'b1;
          e.op       = OP_SIMPLE;
          e.kind0    = KIND_DATA;
          e.val0     = B_IAC;
          phase_next = PH_IDLE;
        end else if (rx_byte == B_DO || rx_byte == B_DONT || rx_byte == B_WILL ||
                     rx_byte == B_WONT) begin
          held_command_next = rx_byte;
          phase_next        = PH_OPT;
        end else if (rx_byte == B_SB) begin
          phase_next = PH_SBOPT;
        end else begin
          phase_next = PH_SKIP1;
        end
      end
      PH_OPT: begin
        if (!replies_off) begin
          if (rx_byte == OPT_TSPEED) begin
            emit = 1'b1;
            e.op = OP_REPLY_BOTH;
          end else if (held_command == B_WILL && rx_byte == OPT_NAWS) begin
            emit = 1'b1;
            e.op = OP_REPLY_NAWS;
          end else if (held_command == B_WILL && rx_byte == OPT_TTYPE) begin
            emit = 1'b1;
            e.op = OP_REPLY_TTYPE;
          end
        end
        phase_next = PH_IDLE;
      end
      PH_SKIP1: begin
        phase_next = PH_IDLE;
      end
      PH_SBOPT: begin
        if (rx_byte == OPT_TTYPE) begin
          phase_next = PH_TTIS;
        end else if (rx_byte == OPT_NAWS) begin
          size_bytes_next     = '{default: 8'd0};
          size_count_next     = 3'd0;
          pending_escape_next = 1'b0;
          phase_next          = PH_NAWS;
        end else if (rx_byte == B_SE) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_SBSKIP;
        end
      end
      PH_TTIS: begin
        if (rx_byte == SUB_IS) begin
          name_count_next     = '0;
          pending_escape_next = 1'b0;
          phase_next          = PH_NAME;
        end else if (rx_byte == B_SE) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_SBSKIP;
        end
      end
      PH_NAME: begin
        if (pending_escape && rx_byte == B_SE) begin
          emit                = 1'b1;
          e.op                = OP_SIMPLE;
          e.kind0             = KIND_ACCEPTED;
          name_count_next     = '0;
          pending_escape_next = 1'b0;
          phase_next          = PH_IDLE;
        end else begin
          // escaped iac that was not followed by se becomes a '?'
          esc_char  = pending_escape && (name_count < NW'(MAX_NAME_CHARS));
          count_mid = NW'(name_count + NW'(esc_char));
          pending_escape_next = (rx_byte == B_IAC);
          if (rx_byte == B_SE) begin
            emit            = 1'b1;
            e.op            = OP_SIMPLE;
            name_count_next = '0;
            phase_next      = PH_IDLE;
            if (esc_char) begin
              e.two   = 1'b1;
              e.kind0 = KIND_NAME;
              e.val0  = CHAR_QMARK;
              e.kind1 = KIND_DISCARD;
            end else begin
              e.kind0 = KIND_DISCARD;
            end
          end else begin
            byte_char       = (rx_byte != B_IAC) && (count_mid < NW'(MAX_NAME_CHARS));
            name_count_next = NW'(count_mid + NW'(byte_char));
            emit            = esc_char || byte_char;
            e.op            = OP_SIMPLE;
            if (esc_char && byte_char) begin
              e.two   = 1'b1;
              e.kind0 = KIND_NAME;
              e.val0  = CHAR_QMARK;
              e.kind1 = KIND_NAME;
              e.val1  = mapped;
            end else if (esc_char) begin
              e.kind0 = KIND_NAME;
              e.val0  = CHAR_QMARK;
            end else begin
              e.kind0 = KIND_NAME;
              e.val0  = mapped;
            end
          end
        end
      end
      PH_NAWS: begin
        if (pending_escape) begin
          pending_escape_next = 1'b0;
          if (rx_byte == B_SE) begin
            emit       = 1'b1;
            e.op       = OP_WINDOW;
            e.kind0    = KIND_WINDOW;
            e.width    = clamp_dim(raw_w, min_dimension, max_dimension);
            e.height   = clamp_dim(raw_h, min_dimension, max_dimension);
            phase_next = PH_IDLE;
          end else if (rx_byte == B_IAC) begin
            if (size_count < 3'd4) begin
              size_bytes_next[size_count[1:0]] = B_IAC;
              size_count_next                  = size_count + 3'd1;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (rx_byte == B_IAC) begin
          pending_escape_next = 1'b1;
        end else if (size_count < 3'd4) begin
          size_bytes_next[size_count[1:0]] = rx_byte;
          size_count_next                  = size_count + 3'd1;
        end
      end
      PH_SBSKIP: begin
        if (rx_byte == B_SE) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if (rx_byte == B_IAC) begin
          phase_next = PH_IAC;
        end else begin
          emit       = 1'b1;
          e.op       = OP_SIMPLE;
          e.kind0    = KIND_DATA;
          e.val0     = rx_byte;
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  assign push  = accept && emit;
  assign entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      held_command   <= 8'd0;
      size_bytes     <= '{default: 8'd0};
      size_count     <= 3'd0;
      name_count     <= '0;
      pending_escape <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      held_command   <= held_command_next;
      size_bytes     <= size_bytes_next;
      size_count     <= size_count_next;
      name_count     <= name_count_next;
      pending_escape <= pending_escape_next;
    end
  end

endmodule

// ===== rtl/tor_queue.sv =====
// ---------------------------------------------------------------------------
// tor_queue
// short entry queue between parser and result sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tor_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tor_pkg::entry_t  push_entry,
  input  logic             pop,
  output tor_pkg::entry_t  head_entry,
  output tor_pkg::qstat_t  stat
);
  import tor_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign head_entry = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(tail + PW'(1));
      end
      if (pop) begin
        head <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(head + PW'(1));
      end
      if (push && !pop) begin
        count <= CW'(count + CW'(1));
      end else if (pop && !push) begin
        count <= CW'(count - CW'(1));
      end
    end
  end

endmodule

// ===== rtl/tor_back.sv =====
// ---------------------------------------------------------------------------
// tor_back
// result sequencer: expands each queued entry into its result words and
// holds them in the output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tor_back (
  input  logic             clk,
  input  logic             rst,
  input  tor_pkg::qstat_t  stat,
  input  tor_pkg::entry_t  head_entry,
  output logic             pop,
  input  logic             res_stall,
  output logic             res_valid,
  output logic [2:0]       kind,
  output logic [7:0]       value,
  output logic [15:0]      width,
  output logic [15:0]      height,
  output logic             last
);
  import tor_pkg::*;

  logic [2:0]  idx;
  logic        load;
  logic        item_last;
  logic [2:0]  item_kind;
  logic [7:0]  item_value;
  logic [15:0] item_width, item_height;

  always_comb begin
    item_kind   = KIND_TX;
    item_value  = reply_byte(head_entry.op, idx);
    item_width  = 16'd0;
    item_height = 16'd0;
    unique case (head_entry.op)
      OP_SIMPLE: begin
        item_kind  = (idx == 3'd0) ? head_entry.kind0 : head_entry.kind1;
        item_value = (idx == 3'd0) ? head_entry.val0 : head_entry.val1;
      end
      OP_WINDOW: begin
        item_kind   = KIND_WINDOW;
        item_value  = 8'd0;
        item_width  = head_entry.width;
        item_height = head_entry.height;
      end
      default: begin
        item_kind = KIND_TX;
      end
    endcase
  end

  assign item_last = (idx == entry_len(head_entry.op, head_entry.two) - 3'd1);
  assign load      = stat.valid && (!res_valid || !res_stall);
  assign pop       = load && item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= item_last ? 3'd0 : idx + 3'd1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind   <= item_kind;
      value  <= item_value;
      width  <= item_width;
      height <= item_height;
      last   <= item_last;
    end
  end

endmodule

// ===== rtl/telnet_option_receive_parser.sv =====
// ---------------------------------------------------------------------------
// telnet_option_receive_parser
// Parses received telnet bytes: data passes through, option commands are
// answered with negotiation bytes, terminal type and window size
// subnegotiations are reported. A received byte is taken every cycle while
// the two-entry queue between parser and sequencer has room; each byte
// that has results leaves one queue entry, and the sequencer sends one result
// word per cycle while not stalled, so a byte with k results gives k words
// (k is at most six, for the reply sequences). Plain data runs at one byte
// per cycle without stalls, passing the queue slot, then the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "telnet_option_receive_parser_defines.svh"

module telnet_option_receive_parser #(
  parameter int MAX_NAME_CHARS = tor_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [7:0]  value,
  output logic [15:0] width,
  output logic [15:0] height,
  output logic        last
);
  import tor_pkg::*;

  logic        replies_off;
  logic [15:0] min_dimension, max_dimension;
  logic        accept;
  logic        push;
  logic        pop;
  entry_t      push_entry, head_entry;
  qstat_t      stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      replies_off   <= 1'b0;
      min_dimension <= MIN_DIM_RESET;
      max_dimension <= MAX_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPLIES_OFF: replies_off   <= cfg_data[0];
        REG_MIN_DIM:     min_dimension <= cfg_data;
        REG_MAX_DIM:     max_dimension <= cfg_data;
        default:         ;
      endcase
    end
  end

  assign rx_stall = stat.full;
  assign accept   = rx_valid && !rx_stall;

  tor_front #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .replies_off  (replies_off),
    .min_dimension(min_dimension),
    .max_dimension(max_dimension),
    .push         (push),
    .entry        (push_entry)
  );

  tor_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head_entry(head_entry),
    .stat      (stat)
  );

  tor_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .head_entry(head_entry),
    .pop       (pop),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .kind      (kind),
    .value     (value),
    .width     (width),
    .height    (height),
    .last      (last)
  );

  `TOR_ASSERT_NOW(a_size_only_window, res_valid && kind != KIND_WINDOW, width == 16'd0 && height == 16'd0)
  `TOR_ASSERT_NOW(a_window_single, res_valid && kind == KIND_WINDOW, last && value == 8'd0)
  `TOR_ASSERT_NOW(a_no_push_full, push, !stat.full || pop)
  `TOR_ASSERT_NEXT(a_push_lands, push, stat.valid)

endmodule
